@@ hdl/msb_first_bit_packer_defines.svh @@
// ----------------------------------------------------------------------------
// msb_first_bit_packer_defines.svh
// Assertion macros shared by the bit packer RTL. Each macro samples on clk
// and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define MBP_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed: lbl");

// Check that a consequent holds in the cycle after its antecedent.
`define MBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`endif

@@ hdl/mbp_pkg.sv @@
// ----------------------------------------------------------------------------
// mbp_pkg
// Types and fixed field widths of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

	localparam int CODE_W    = 32;
	localparam int LEN_W     = 6;
	localparam int OUT_W     = 32;
	localparam int BYTES_W   = 3;
	localparam int MAX_BYTES = 4;

	// Transaction kind
	typedef enum logic {
		MODE_PUT   = 1'b0,
		MODE_FLUSH = 1'b1
	} mode_t;

	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [OUT_W-1:0]   word_t;
	typedef logic [BYTES_W-1:0] nbytes_t;

endpackage

@@ hdl/mbp_in_if.sv @@
// ----------------------------------------------------------------------------
// mbp_in_if
// Input channel of the bit packer: put or flush transactions.
// ----------------------------------------------------------------------------
interface mbp_in_if import mbp_pkg::*; ;

	logic  valid;
	logic  ready;
	mode_t mode;
	code_t code;
	len_t  length;

	modport source (output valid, output mode, output code, output length, input ready);
	modport sink   (input valid, input mode, input code, input length, output ready);

endinterface

@@ hdl/mbp_out_if.sv @@
// ----------------------------------------------------------------------------
// mbp_out_if
// Output channel of the bit packer: emitted bytes, left-aligned.
// ----------------------------------------------------------------------------
interface mbp_out_if import mbp_pkg::*; ;

	logic    valid;
	logic    ready;
	word_t   out_word;
	nbytes_t out_bytes;

	modport source (output valid, output out_word, output out_bytes, input ready);
	modport sink   (input valid, input out_word, input out_bytes, output ready);

endinterface

@@ hdl/msb_first_bit_packer.sv @@
// A result is valid in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; the accumulator update is a single
// shift-and-merge pass into the state and result registers.
// Input ready drops only while the result register is full and stalled.
// Reset (arst_n low) empties the accumulator, sets all bits free and drops
// the result valid.
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-length codes MSB first into a WORD_BITS accumulator and
// emits full words, or the pending bytes zero-padded on a flush.
// ----------------------------------------------------------------------------
`include "msb_first_bit_packer_defines.svh"

module msb_first_bit_packer import mbp_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	mbp_in_if.sink    in_item,
	mbp_out_if.source out_item
);

	localparam int FB_W = $clog2(WORD_BITS + 1);
	localparam int CNT_W = FB_W + 1;
	localparam int LEN_CAP_I = (WORD_BITS < CODE_W) ? WORD_BITS : CODE_W;
	localparam int WBYTES_I = ((WORD_BITS / 8) > MAX_BYTES) ? MAX_BYTES : (WORD_BITS / 8);

	localparam logic [CNT_W-1:0] WB_C      = CNT_W'(WORD_BITS);
	localparam logic [CNT_W-1:0] LEN_CAP   = CNT_W'(LEN_CAP_I);
	localparam logic [CNT_W-1:0] MAXB_C    = CNT_W'(MAX_BYTES);
	localparam nbytes_t          WORD_NB   = BYTES_W'(WBYTES_I);
	localparam logic [FB_W-1:0]  FREE_FULL = FB_W'(WORD_BITS);

	// Left-align a word into the 32-bit output field
	function automatic word_t top32(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS+OUT_W-1:0] wide;
		wide = {w, {OUT_W{1'b0}}};
		return wide[WORD_BITS+OUT_W-1 -: OUT_W];
	endfunction

	logic [WORD_BITS-1:0] acc_q;
	logic [FB_W-1:0]      free_q;
	logic                 out_valid_q;
	word_t                out_word_q;
	nbytes_t              out_bytes_q;

	logic                 accept;
	logic [CNT_W-1:0]     len_in;
	logic [CNT_W-1:0]     len_c;
	logic [CNT_W-1:0]     free_c;
	logic [CNT_W-1:0]     rest;
	logic [CNT_W-1:0]     pending;
	logic [CNT_W-1:0]     flush_nb;
	code_t                code_m;
	logic [63:0]          code_64;
	logic [WORD_BITS-1:0] code_w;
	logic [WORD_BITS-1:0] acc_n;
	logic [FB_W-1:0]      free_n;
	word_t                word_n;
	nbytes_t              bytes_n;

	// Accept whenever the result register is empty or being drained
	assign in_item.ready = !out_valid_q || out_item.ready;
	assign accept = in_item.valid && in_item.ready;

	// Clamp the length, mask the code and compute the next state and result
	always_comb begin
		len_in  = CNT_W'(in_item.length);
		len_c   = (len_in > LEN_CAP) ? LEN_CAP : len_in;
		free_c  = CNT_W'(free_q);
		code_m  = in_item.code & ~({CODE_W{1'b1}} << len_c);
		code_64 = {32'b0, code_m};
		code_w  = code_64[WORD_BITS-1:0];
		rest    = len_c - free_c;
		pending = WB_C - free_c;
		flush_nb = (pending + CNT_W'(7)) >> 3;
		if (flush_nb > MAXB_C) begin
			flush_nb = MAXB_C;
		end
		acc_n   = acc_q;
		free_n  = free_q;
		word_n  = '0;
		bytes_n = '0;
		unique case (in_item.mode)
			MODE_FLUSH: begin
				acc_n  = '0;
				free_n = FREE_FULL;
				if (flush_nb != '0) begin
					word_n  = top32(acc_q << free_c);
					bytes_n = BYTES_W'(flush_nb);
				end
			end
			MODE_PUT: begin
				if (len_c < free_c) begin
					acc_n  = (acc_q << len_c) | code_w;
					free_n = FB_W'(free_c - len_c);
				end else begin
					word_n  = top32((acc_q << free_c) | (code_w >> rest));
					bytes_n = WORD_NB;
					acc_n   = code_w & ~({WORD_BITS{1'b1}} << rest);
					free_n  = FB_W'(WB_C - rest);
				end
			end
			default: begin
				acc_n  = acc_q;
				free_n = free_q;
			end
		endcase
	end

	// Advance the accumulator state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			free_q <= FREE_FULL;
		end else if (accept) begin
			acc_q  <= acc_n;
			free_q <= free_n;
		end
	end

	// Hold the result until taken; load a new one on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_word_q  <= word_n;
			out_bytes_q <= bytes_n;
		end
	end

	assign out_item.valid     = out_valid_q;
	assign out_item.out_word  = out_word_q;
	assign out_item.out_bytes = out_bytes_q;

	// Pending bit count seen by the checks below
	logic [CNT_W-1:0] chk_pending;
	assign chk_pending = WB_C - CNT_W'(free_q);

	`MBP_ASSERT_ALWAYS(a_free_range, (free_q != '0) && (CNT_W'(free_q) <= WB_C))
	`MBP_ASSERT_ALWAYS(a_acc_clean, (acc_q >> chk_pending) == '0)
	`MBP_ASSERT_ALWAYS(a_stall_full, in_item.ready || out_item.valid)
	`MBP_ASSERT_ALWAYS(a_bytes_cap, !out_item.valid || (CNT_W'(out_item.out_bytes) <= MAXB_C))
	`MBP_ASSERT_NEXT(a_flush_empty, accept && (in_item.mode == MODE_FLUSH), (free_q == FREE_FULL) && (acc_q == '0))

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MSB-first bit packer. Put and flush
// transactions go in through the input channel. A local model of the
// accumulator predicts each emitted word and byte count, and the result
// channel is checked in order against it. The bench runs directed edge cases
// and then random traffic under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb import mbp_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          PACK_BITS   = 32;
	localparam int          CLK_PERIOD  = 10;
	localparam int          RESET_TICKS = 12;
	localparam int          DRAIN_TICKS = 4;
	localparam int unsigned CYCLE_LIMIT = 500000;

	// One emitted result: left-aligned bytes and their count
	typedef struct packed {
		word_t   word;
		nbytes_t nbytes;
	} emit_t;

	logic clk;
	logic arst_n;

	mbp_in_if  in_ch ();
	mbp_out_if out_ch ();

	msb_first_bit_packer #(
		.WORD_BITS(PACK_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_ch),
		.out_item (out_ch)
	);

	// Packing model state
	logic [31:0] pack_acc;
	int unsigned pack_free;
	emit_t       expected_words[$];

	// Idling mix, in percent of cycles
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// Run statistics
	int unsigned cycle_count;
	int unsigned error_count;
	int unsigned puts_sent;
	int unsigned flushes_sent;
	int unsigned full_words_seen;
	int unsigned partial_flushes_seen;
	int unsigned empty_results_seen;
	emit_t       got_r;
	emit_t       want_r;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Update the model with one accepted transaction and queue its result
	task automatic predict_packing(input mode_t m, input code_t c, input len_t l);
		logic [63:0] merged;
		logic [63:0] bits;
		int unsigned n;
		int unsigned pending;
		int unsigned spill;
		emit_t       r;
		r.word   = '0;
		r.nbytes = '0;
		if (m == MODE_FLUSH) begin
			// Pad pending bits with zeros and left-align them
			pending = PACK_BITS - pack_free;
			if (pending != 0) begin
				merged   = {32'b0, pack_acc} << pack_free;
				r.word   = merged[31:0];
				r.nbytes = nbytes_t'((pending + 7) / 8);
			end
			pack_acc  = '0;
			pack_free = PACK_BITS;
		end else begin
			// Saturate the length and mask the code above it
			n    = (l > 32) ? 32 : int'(l);
			bits = {32'b0, c} & ((64'd1 << n) - 64'd1);
			if (n < pack_free) begin
				merged    = ({32'b0, pack_acc} << n) | bits;
				pack_acc  = merged[31:0];
				pack_free = pack_free - n;
			end else begin
				// Word fills: emit it, leftover bits start the next word
				spill     = n - pack_free;
				merged    = ({32'b0, pack_acc} << pack_free) | (bits >> spill);
				r.word    = merged[31:0];
				r.nbytes  = nbytes_t'(MAX_BYTES);
				bits      = bits & ((64'd1 << spill) - 64'd1);
				pack_acc  = bits[31:0];
				pack_free = PACK_BITS - spill;
			end
		end
		expected_words.push_back(r);
	endtask

	// Drive one transaction and hold it until accepted
	task automatic send_item(input mode_t m, input code_t c, input len_t l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.mode   <= m;
		in_ch.code   <= c;
		in_ch.length <= l;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_packing(m, c, l);
		if (m == MODE_FLUSH)
			flushes_sent++;
		else
			puts_sent++;
		@(negedge clk);
	endtask

	task automatic put_code(input code_t c, input int unsigned l);
		send_item(MODE_PUT, c, len_t'(l));
	endtask

	task automatic flush_bits();
		send_item(MODE_FLUSH, code_t'($urandom), len_t'($urandom_range(63)));
	endtask

	// Empty puts, single bits, full words, masking and length saturation
	task automatic test_length_extremes();
		put_code(32'hFFFF_FFFF, 0);
		put_code(32'hFFFF_FFFF, 1);
		put_code(32'h0000_0000, 1);
		put_code(32'hFFFF_FFFF, 3);
		put_code(32'hDEAD_BEEF, 27);
		put_code(32'hFFFF_FFFF, 32);
		put_code(32'hA5A5_A5A5, 32);
		put_code(32'h1234_5678, 33);
		put_code(32'h8765_4321, 63);
		put_code(32'hFFFF_FFFF, 40);
	endtask

	// Flush when empty, and flushes of one, two and four pending bytes
	task automatic test_flush_padding();
		flush_bits();
		flush_bits();
		put_code(32'h0000_0001, 1);
		flush_bits();
		put_code(32'h0000_00C3, 8);
		flush_bits();
		put_code(32'h0000_01FF, 9);
		flush_bits();
		put_code(32'h7FFF_FFFF, 31);
		flush_bits();
	endtask

	// Codes that straddle a word boundary or fill it exactly
	task automatic test_word_straddle();
		put_code(32'h000A_BCDE, 20);
		put_code(32'h0001_2345, 20);
		put_code(32'h0000_0ABC, 12);
		put_code(32'h0000_0FFF, 12);
		put_code(32'h000F_FFFF, 20);
		flush_bits();
	endtask

	// Random puts and flushes under one idling mix
	task automatic test_random_packing(input int unsigned count,
		input int unsigned send_pct, input int unsigned recv_pct);
		int unsigned sel;
		int unsigned csel;
		int unsigned l;
		code_t       c;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) begin
			sel  = $urandom_range(99);
			csel = $urandom_range(99);
			if (csel < 5)
				c = '0;
			else if (csel < 10)
				c = '1;
			else
				c = code_t'($urandom);
			if (sel < 8) begin
				flush_bits();
			end else begin
				if (sel < 11)
					l = $urandom_range(63, 33);
				else if (sel < 21)
					l = 32;
				else if (sel < 25)
					l = 0;
				else if (sel < 60)
					l = $urandom_range(8, 1);
				else
					l = $urandom_range(31, 1);
				put_code(c, l);
			end
		end
	endtask

	// Stall the result channel at random
	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got_r.word   = out_ch.out_word;
			got_r.nbytes = out_ch.out_bytes;
			if (expected_words.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result word=%h bytes=%0d", $time,
					got_r.word, got_r.nbytes);
			end else begin
				want_r = expected_words.pop_front();
				if (got_r.word !== want_r.word) begin
					error_count++;
					$display("%0t: out_word mismatch: expected %h, actual %h", $time,
						want_r.word, got_r.word);
				end
				if (got_r.nbytes !== want_r.nbytes) begin
					error_count++;
					$display("%0t: out_bytes mismatch: expected %0d, actual %0d", $time,
						want_r.nbytes, got_r.nbytes);
				end
				if (want_r.nbytes == nbytes_t'(0))
					empty_results_seen++;
				else if (want_r.nbytes == nbytes_t'(MAX_BYTES))
					full_words_seen++;
				else
					partial_flushes_seen++;
			end
		end
	end

	// Abort a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
			cycle_count, expected_words.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.mode           = MODE_PUT;
		in_ch.code           = '0;
		in_ch.length         = '0;
		out_ch.ready         = 1'b0;
		pack_acc             = '0;
		pack_free            = PACK_BITS;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		error_count          = 0;
		puts_sent            = 0;
		flushes_sent         = 0;
		full_words_seen      = 0;
		partial_flushes_seen = 0;
		empty_results_seen   = 0;

		// Hold reset, then release on a falling edge
		repeat (RESET_TICKS) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_length_extremes();
		test_flush_padding();
		test_word_straddle();
		test_random_packing(225, 0, 0);
		test_random_packing(225, 88, 0);
		test_random_packing(225, 0, 88);
		test_random_packing(225, 37, 37);
		in_ch.valid <= 1'b0;

		// Drain outstanding results
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);

		$display("Sent %0d puts and %0d flushes over %0d cycles", puts_sent,
			flushes_sent, cycle_count);
		$display("Results: %0d full words, %0d partial flushes, %0d empty",
			full_words_seen, partial_flushes_seen, empty_results_seen);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d errors", error_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
